FILE: sv/esl_pkg.sv
// esl_pkg: shared types and constants of the esc arming slew limiter
// used by esl_lane and esc_arming_slew_limiter_top, no dependencies
package esl_pkg;

  localparam int LANES    = 4;
  localparam int PULSE_W  = 11;
  localparam int THR_W    = 11;
  localparam int STEP_W   = 8;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [THR_W-1:0]   THROTTLE_FULL = 11'd1024;
  localparam logic [PULSE_W-1:0] PULSE_LIMIT   = 11'h7FF;

  localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 11'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 11'd2000;
  localparam logic [STEP_W-1:0]  RAMP_STEP_RST = 8'd20;
  localparam logic [STEP_W-1:0]  ARM_STEP_RST  = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_MIN = 2'd0,
    REG_PULSE_MAX = 2'd1,
    REG_RAMP_STEP = 2'd2,
    REG_ARM_STEP  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_min;
    logic [PULSE_W-1:0] pulse_max;
    logic [STEP_W-1:0]  ramp_step;
    logic [STEP_W-1:0]  arm_step;
  } cfg_t;

  typedef struct packed {
    logic advance;
    logic actuate;
    logic armed;
  } lane_ctrl_t;

  typedef struct packed {
    logic changed;
    logic rose;
  } lane_stat_t;

endpackage

FILE: sv/esl_lane.sv
// esl_lane: one motor lane, holds its setpoint and computes the next one
// depends on esl_pkg
module esl_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  esl_pkg::cfg_t               cfg,
  input  esl_pkg::lane_ctrl_t         ctrl,
  input  logic [esl_pkg::THR_W-1:0]   throttle,
  output logic [esl_pkg::PULSE_W-1:0] sp_next,
  output esl_pkg::lane_stat_t         stat
);
  import esl_pkg::*;

  logic [PULSE_W-1:0] setpoint;
  logic [THR_W-1:0]   thr;
  logic signed [11:0] span;
  logic signed [23:0] prod;
  logic signed [12:0] target;
  logic signed [12:0] delta;
  logic signed [12:0] rs;
  logic signed [12:0] dlim;
  logic signed [12:0] v;
  logic signed [12:0] hi;
  logic signed [12:0] lo;
  logic signed [12:0] vc;
  logic [PULSE_W:0]   arm_sum;
  logic [PULSE_W-1:0] arm_val;
  logic [PULSE_W-1:0] run_val;

  // armed path: target, signed slew clamp, range clamp
  always_comb begin
    thr    = (throttle > THROTTLE_FULL) ? THROTTLE_FULL : throttle;
    hi     = $signed({2'b00, cfg.pulse_max});
    lo     = $signed({2'b00, cfg.pulse_min});
    span   = $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_min});
    prod   = span * $signed({1'b0, thr});
    target = lo + $signed(prod[22:10]);
    delta  = target - $signed({2'b00, setpoint});
    rs     = $signed({5'b00000, cfg.ramp_step});
    if (delta > rs) begin
      dlim = rs;
    end else if (delta < -rs) begin
      dlim = -rs;
    end else begin
      dlim = delta;
    end
    v = $signed({2'b00, setpoint}) + dlim;
    if (v > hi) begin
      vc = hi;
    end else if (v < lo) begin
      vc = lo;
    end else begin
      vc = v;
    end
    run_val = vc[PULSE_W-1:0];
  end

  // arming path, saturating add
  always_comb begin
    arm_sum = {1'b0, setpoint} + {{(PULSE_W+1-STEP_W){1'b0}}, cfg.arm_step};
    arm_val = arm_sum[PULSE_W] ? PULSE_LIMIT : arm_sum[PULSE_W-1:0];
  end

  always_comb begin
    stat = '0;
    priority if (!ctrl.actuate) begin
      sp_next      = '0;
      stat.changed = 1'b1;
    end else if (ctrl.armed) begin
      sp_next      = run_val;
      stat.changed = (run_val != setpoint);
    end else if (setpoint < cfg.pulse_min) begin
      sp_next      = arm_val;
      stat.changed = 1'b1;
      stat.rose    = 1'b1;
    end else begin
      sp_next = setpoint;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= '0;
    end else if (ctrl.advance) begin
      setpoint <= sp_next;
    end
  end

endmodule

FILE: sv/esc_arming_slew_limiter_top.sv
// Arming and slew-rate limiter for four motor pulse widths. One input beat is
// one control tick and yields exactly one output beat. A new beat is taken
// every cycle while the output register is empty or being drained, so the
// sustained rate is one tick per clock; each result is captured in the output
// register when its beat is taken. The cycle is set by the per-lane path: a
// 12x12 multiply for the target, then the signed slew clamp and range clamp,
// all four lanes in parallel, merged into the write mask and armed flag.
// Depends on esl_pkg and esl_lane.
module esc_arming_slew_limiter_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [esl_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [esl_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // actuate[0], throttle_0[11:1], throttle_1[22:12], throttle_2[33:23],
  // throttle_3[44:34], zero fill
  input  logic [47:0]                      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pulse_0[10:0], pulse_1[21:11], pulse_2[32:22], pulse_3[43:33],
  // write_mask[47:44], armed[48], zero fill
  output logic [55:0]                      m_axis_tdata
);
  import esl_pkg::*;

  cfg_t               cfg;
  logic               armed_flag;
  logic               armed_next;
  logic               s_acc;
  lane_ctrl_t         ctrl;
  logic [PULSE_W-1:0] sp_next [LANES];
  lane_stat_t         stat    [LANES];
  logic [LANES-1:0]   mask;
  logic [LANES-1:0]   rose;
  logic               out_valid;
  logic [55:0]        out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_min <= PULSE_MIN_RST;
      cfg.pulse_max <= PULSE_MAX_RST;
      cfg.ramp_step <= RAMP_STEP_RST;
      cfg.arm_step  <= ARM_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_PULSE_MIN: cfg.pulse_min <= cfg_data[PULSE_W-1:0];
        REG_PULSE_MAX: cfg.pulse_max <= cfg_data[PULSE_W-1:0];
        REG_RAMP_STEP: cfg.ramp_step <= cfg_data[STEP_W-1:0];
        REG_ARM_STEP:  cfg.arm_step  <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign ctrl.advance = s_acc;
  assign ctrl.actuate = s_axis_tdata[0];
  assign ctrl.armed   = armed_flag;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    esl_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .cfg      (cfg),
      .ctrl     (ctrl),
      .throttle (s_axis_tdata[1 + i*THR_W +: THR_W]),
      .sp_next  (sp_next[i]),
      .stat     (stat[i])
    );
    assign mask[i] = stat[i].changed;
    assign rose[i] = stat[i].rose;
  end

  // merge lanes into armed flag
  always_comb begin
    priority if (!ctrl.actuate) begin
      armed_next = 1'b0;
    end else if (armed_flag) begin
      armed_next = 1'b1;
    end else begin
      armed_next = (rose == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (s_acc) begin
        armed_flag <= armed_next;
        out_valid  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      out_data <= {7'd0, armed_next, mask, sp_next[3], sp_next[2], sp_next[1], sp_next[0]};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  a_disable_beat: assert property (@(posedge clk) disable iff (rst)
    s_acc && !s_axis_tdata[0] |=> m_axis_tvalid && m_axis_tdata[47:44] == 4'hF
      && m_axis_tdata[43:0] == 44'd0 && !m_axis_tdata[48])
    else $error("disable beat did not zero all pulses");

  a_arm_done: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_axis_tdata[0] && !armed_flag |=>
      m_axis_tdata[48] == (m_axis_tdata[47:44] == 4'h0))
    else $error("armed flag disagrees with arming mask");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result stalled");

  a_armed_state: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> armed_flag == m_axis_tdata[48])
    else $error("armed state and result armed bit differ");

endmodule
